// ===== rtl/core/crbm_pkg.sv =====
// Package for the cartridge RAM bank mapper: widths, decode constants,
// the bank pair tables and the stage record shared by the core modules.
// No dependencies.
package crbm_pkg;

  localparam int ADDR_W         = 13;
  localparam int DATA_W         = 8;
  localparam int SEL_W          = 2;
  localparam int CNT_W          = 3;
  localparam int STORE_BANKS    = 4;
  localparam int BANK_BYTES_DEF = 2048;

  localparam logic [ADDR_W-1:0] SWITCH_ADDR  = 13'h1FF8;
  localparam logic [ADDR_W-1:0] LOAD_ADDR    = 13'h1FF9;
  localparam logic [ADDR_W-1:0] LATCH_MASK   = 13'h0F00;
  localparam logic [ADDR_W-1:0] LOW_PAGE_MAX = 13'h00FF;
  localparam logic [ADDR_W-1:0] HIGH_HALF    = 13'h1800;
  localparam logic [ADDR_W-1:0] CART_BASE    = 13'h1000;

  localparam logic [DATA_W-1:0] PAIR_MASK = 8'h1C;
  localparam logic [DATA_W-1:0] WE_MASK   = 8'h02;

  localparam logic [SEL_W-1:0] RAM_BANK0  = 2'd0;
  localparam logic [SEL_W-1:0] RAM_BANK1  = 2'd1;
  localparam logic [SEL_W-1:0] RAM_BANK2  = 2'd2;
  localparam logic [SEL_W-1:0] ROM_SELECT = 2'd3;

  localparam logic [CNT_W-1:0] CNT_WRITE = 3'd5;
  localparam logic [CNT_W-1:0] CNT_HOLD  = 3'd6;

  // Access result carried from the decode stage to the output register
  typedef struct packed {
    logic              drive;
    logic              use_pending;
    logic [DATA_W-1:0] pending;
    logic              req;
    logic [DATA_W-1:0] id;
  } s1_t;

  function automatic logic [SEL_W-1:0] pair_low(input logic [2:0] pair);
    logic [SEL_W-1:0] sel;
    case (pair)
      3'd0: sel = RAM_BANK2;
      3'd1: sel = RAM_BANK0;
      3'd2: sel = RAM_BANK2;
      3'd3: sel = RAM_BANK0;
      3'd4: sel = RAM_BANK2;
      3'd5: sel = RAM_BANK1;
      3'd6: sel = RAM_BANK2;
      default: sel = RAM_BANK1;
    endcase
    return sel;
  endfunction

  function automatic logic [SEL_W-1:0] pair_high(input logic [2:0] pair);
    logic [SEL_W-1:0] sel;
    case (pair)
      3'd0: sel = ROM_SELECT;
      3'd1: sel = ROM_SELECT;
      3'd2: sel = RAM_BANK0;
      3'd3: sel = RAM_BANK2;
      3'd4: sel = ROM_SELECT;
      3'd5: sel = ROM_SELECT;
      3'd6: sel = RAM_BANK1;
      default: sel = RAM_BANK2;
    endcase
    return sel;
  endfunction

endpackage

// ===== rtl/core/crbm_if.sv =====
// Valid/ready channel interfaces for the bank mapper: access input and
// result output. Depends on crbm_pkg.
interface crbm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [crbm_pkg::ADDR_W-1:0]   address;
  logic [crbm_pkg::DATA_W-1:0]   data;

  modport source (output valid, mode, address, data, input ready);
  modport sink   (input valid, mode, address, data, output ready);
endinterface

interface crbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [crbm_pkg::DATA_W-1:0]   read_data;
  logic                          drive_bus;
  logic                          load_request;
  logic [crbm_pkg::DATA_W-1:0]   load_id;

  modport source (output valid, read_data, drive_bus, load_request, load_id, input ready);
  modport sink   (input valid, read_data, drive_bus, load_request, load_id, output ready);
endinterface

// ===== rtl/core/crbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/crbm_ctrl.sv =====
// Bank mapper decode and state: bank selects, write enable, pending byte,
// access counter and previous address; issues bank store accesses.
// Depends on crbm_pkg.
module crbm_ctrl #(
  parameter int BANK_BYTES = crbm_pkg::BANK_BYTES_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                acc,
  input  logic                                                mode,
  input  logic [crbm_pkg::ADDR_W-1:0]                         address,
  input  logic [crbm_pkg::DATA_W-1:0]                         data,
  output logic                                                ram_we,
  output logic [$clog2(crbm_pkg::STORE_BANKS*BANK_BYTES)-1:0] ram_waddr,
  output logic [crbm_pkg::DATA_W-1:0]                         ram_wdata,
  output logic [$clog2(crbm_pkg::STORE_BANKS*BANK_BYTES)-1:0] ram_raddr,
  output crbm_pkg::s1_t                                       s1_info
);

  localparam int OFF_W = $clog2(BANK_BYTES);
  localparam int ST_W  = $clog2(crbm_pkg::STORE_BANKS * BANK_BYTES);

  logic [crbm_pkg::SEL_W-1:0]  lsel_r, lsel_nxt;
  logic [crbm_pkg::SEL_W-1:0]  hsel_r, hsel_nxt;
  logic                        we_r, we_nxt;
  logic [crbm_pkg::DATA_W-1:0] pend_r, pend_nxt;
  logic [crbm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_mid;
  logic [crbm_pkg::ADDR_W-1:0] prev_r, prev_nxt;

  logic                        cart, low_half, timed, writable, wr_c;
  logic                        req_c, latch_c, switch_c;
  logic [crbm_pkg::SEL_W-1:0]  sel;
  logic [ST_W-1:0]             idx;
  logic [2:0]                  pair;

  assign cart     = (address & crbm_pkg::CART_BASE) != '0;
  assign low_half = address < crbm_pkg::HIGH_HALF;
  assign sel      = low_half ? lsel_r : hsel_r;
  assign idx      = {sel, address[OFF_W-1:0]};
  assign timed    = we_r && (cnt_r == crbm_pkg::CNT_WRITE);
  assign writable = low_half || (hsel_r != crbm_pkg::ROM_SELECT);
  assign wr_c     = timed && writable;
  assign pair     = 3'((pend_r & crbm_pkg::PAIR_MASK) >> 2);

  assign req_c    = (address == crbm_pkg::LOAD_ADDR) && (hsel_r == crbm_pkg::ROM_SELECT)
                    && (prev_r <= crbm_pkg::LOW_PAGE_MAX);
  assign latch_c  = ((address & crbm_pkg::LATCH_MASK) == '0)
                    && ((cnt_r > crbm_pkg::CNT_WRITE) || !we_r);
  assign switch_c = address == crbm_pkg::SWITCH_ADDR;

  always_comb begin
    lsel_nxt = lsel_r;
    hsel_nxt = hsel_r;
    we_nxt   = we_r;
    pend_nxt = pend_r;
    cnt_mid  = cnt_r;
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    ram_we   = 1'b0;
    if (acc && mode) begin
      ram_we = 1'b1;
    end else if (acc) begin
      if (cart) begin
        if (req_c) begin
          cnt_mid = cnt_r;
        end else if (latch_c) begin
          pend_nxt = address[crbm_pkg::DATA_W-1:0];
          cnt_mid  = '0;
        end else if (switch_c) begin
          cnt_mid  = crbm_pkg::CNT_HOLD;
          we_nxt   = (pend_r & crbm_pkg::WE_MASK) != '0;
          lsel_nxt = crbm_pkg::pair_low(pair);
          hsel_nxt = crbm_pkg::pair_high(pair);
        end else if (wr_c) begin
          ram_we = 1'b1;
        end
      end
      cnt_nxt  = (cnt_mid < crbm_pkg::CNT_HOLD) ? cnt_mid + 1'b1 : cnt_mid;
      prev_nxt = address;
    end
  end

  assign ram_waddr = mode ? address[ST_W-1:0] : idx;
  assign ram_wdata = mode ? data : pend_r;
  assign ram_raddr = idx;

  always_comb begin
    s1_info.drive       = !mode && cart;
    s1_info.use_pending = wr_c;
    s1_info.pending     = pend_r;
    s1_info.req         = !mode && cart && req_c;
    s1_info.id          = (!mode && cart && req_c) ? data : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsel_r <= crbm_pkg::RAM_BANK0;
      hsel_r <= crbm_pkg::ROM_SELECT;
      we_r   <= 1'b0;
      pend_r <= '0;
      cnt_r  <= '0;
      prev_r <= '0;
    end else begin
      lsel_r <= lsel_nxt;
      hsel_r <= hsel_nxt;
      we_r   <= we_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      prev_r <= prev_nxt;
    end
  end

  a_switch_holds_counter: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !mode && (address == crbm_pkg::SWITCH_ADDR) |=> cnt_r == crbm_pkg::CNT_HOLD)
    else $error("counter not parked after bank switch");

  a_fill_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    acc && mode |=> $stable(lsel_r) && $stable(hsel_r) && $stable(cnt_r) && $stable(prev_r))
    else $error("fill transaction changed mapper state");

  a_latch_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !mode && cart && !req_c && latch_c |=> cnt_r == 3'd1)
    else $error("latch did not restart access counter");

endmodule

// ===== rtl/core/cartridge_ram_bank_mapper.sv =====
// Top level of the cartridge RAM bank mapper: decode/state unit, bank store
// and output register. Depends on crbm_pkg, crbm_if, crbm_ram, crbm_ctrl.
//
// Every input transaction (a console bus access or a host fill) yields
// exactly one result transaction. One transaction is taken per clock while
// the output is not stalled; the decode stage holds the registered read of
// the single bank store (8 KiB: three 2 KiB RAM banks and the ROM bank) and
// passes it on to the output register, which makes the result valid. The
// bank store comes out of reset unwritten and gets no clearing pass: the
// host must fill the ROM bank and any RAM read before the console uses it.
// The input accepts while the decode stage is empty or can pass its
// transaction on to the output register, which is free or being emptied.
module cartridge_ram_bank_mapper #(
  parameter int BANK_BYTES = crbm_pkg::BANK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  crbm_in_if.sink           in_item,
  crbm_out_if.source        out_item
);

  localparam int ST_W = $clog2(crbm_pkg::STORE_BANKS * BANK_BYTES);

  logic                        acc, out_free;
  logic                        ram_we;
  logic [ST_W-1:0]             ram_waddr, ram_raddr;
  logic [crbm_pkg::DATA_W-1:0] ram_wdata, ram_rdata;
  crbm_pkg::s1_t               s1_info, s1_r;
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [crbm_pkg::DATA_W-1:0] rd_r, rd_nxt, id_r;
  logic                        drive_r, req_r;

  assign out_free      = !out_valid_r || out_item.ready;
  assign in_item.ready = !s1_valid_r || out_free;
  assign acc           = in_item.valid && in_item.ready;

  crbm_ctrl #(.BANK_BYTES(BANK_BYTES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .mode      (in_item.mode),
    .address   (in_item.address),
    .data      (in_item.data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .s1_info   (s1_info)
  );

  crbm_ram #(
    .WIDTH (crbm_pkg::DATA_W),
    .DEPTH (crbm_pkg::STORE_BANKS * BANK_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (!s1_r.drive) begin
      rd_nxt = '0;
    end else if (s1_r.use_pending) begin
      rd_nxt = s1_r.pending;
    end else begin
      rd_nxt = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (acc) begin
      s1_r <= s1_info;
    end
    if (s1_valid_r && out_free) begin
      rd_r    <= rd_nxt;
      drive_r <= s1_r.drive;
      req_r   <= s1_r.req;
      id_r    <= s1_r.id;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.read_data    = rd_r;
  assign out_item.drive_bus    = drive_r;
  assign out_item.load_request = req_r;
  assign out_item.load_id      = id_r;

  a_stage_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("stalled transaction dropped from decode stage");

  a_req_drives: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.req |-> s1_r.drive && !s1_r.use_pending)
    else $error("load request outside a cartridge access");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid_r)
    else $error("decoded transaction did not reach output register");

endmodule

// ===== tb/bank_map_checker.sv =====
`timescale 1ns / 100ps
// Checker for the cartridge RAM bank mapper: watches both channels, predicts
// each result transaction from the accepted access and compares field by field.
// Depends on crbm_pkg and crbm_if.
module bank_map_checker (
  input  logic clk,
  input  logic rst_n,
  crbm_in_if   in_mon,
  crbm_out_if  out_mon,
  output int   fail_count,
  output int   outstanding
);

  localparam int OFF_W = $clog2(crbm_pkg::BANK_BYTES_DEF);

  // bank pair tables, pair 0 in the low bits
  localparam logic [15:0] LOW_OF_PAIR  = {2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2};
  localparam logic [15:0] HIGH_OF_PAIR = {2'd2, 2'd1, 2'd3, 2'd3, 2'd2, 2'd0, 2'd3, 2'd3};

  typedef struct packed {
    logic [crbm_pkg::DATA_W-1:0] read_data;
    logic                        drive_bus;
    logic                        load_request;
    logic [crbm_pkg::DATA_W-1:0] load_id;
  } answer_t;

  logic [crbm_pkg::DATA_W-1:0] image [crbm_pkg::STORE_BANKS*crbm_pkg::BANK_BYTES_DEF];
  logic [crbm_pkg::SEL_W-1:0]  low_sel;
  logic [crbm_pkg::SEL_W-1:0]  high_sel;
  logic                        wr_en;
  logic [crbm_pkg::DATA_W-1:0] pending;
  logic [crbm_pkg::CNT_W-1:0]  count;
  logic [crbm_pkg::ADDR_W-1:0] last_addr;

  answer_t answers_due [$];

  initial fail_count = 0;
  initial outstanding = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic answer_t mapper_answer(input logic m,
                                            input logic [crbm_pkg::ADDR_W-1:0] a,
                                            input logic [crbm_pkg::DATA_W-1:0] d);
    answer_t                     ans;
    logic                        low_half;
    logic                        timed;
    logic                        writable;
    logic [crbm_pkg::SEL_W-1:0]  sel;
    logic [crbm_pkg::ADDR_W-1:0] idx;
    logic [2:0]                  pair;
    ans = '0;
    if (m) begin
      image[a] = d;
      return ans;
    end
    if ((a & crbm_pkg::CART_BASE) != 0) begin
      low_half = a < crbm_pkg::HIGH_HALF;
      sel      = low_half ? low_sel : high_sel;
      timed    = wr_en && (count == crbm_pkg::CNT_WRITE);
      writable = low_half || (high_sel != crbm_pkg::ROM_SELECT);
      idx      = {sel, a[OFF_W-1:0]};
      ans.drive_bus = 1'b1;
      ans.read_data = (timed && writable) ? pending : image[idx];
      if (a == crbm_pkg::LOAD_ADDR && high_sel == crbm_pkg::ROM_SELECT
          && last_addr <= crbm_pkg::LOW_PAGE_MAX) begin
        ans.load_request = 1'b1;
        ans.load_id      = d;
      end else if ((a & crbm_pkg::LATCH_MASK) == 0
                   && (count > crbm_pkg::CNT_WRITE || !wr_en)) begin
        pending = a[crbm_pkg::DATA_W-1:0];
        count   = '0;
      end else if (a == crbm_pkg::SWITCH_ADDR) begin
        pair     = 3'((pending & crbm_pkg::PAIR_MASK) >> 2);
        count    = crbm_pkg::CNT_HOLD;
        wr_en    = (pending & crbm_pkg::WE_MASK) != 0;
        low_sel  = LOW_OF_PAIR[pair*2 +: 2];
        high_sel = HIGH_OF_PAIR[pair*2 +: 2];
      end else if (timed && writable) begin
        image[idx] = pending;
      end
    end
    if (count < crbm_pkg::CNT_HOLD) count = count + 1'b1;
    last_addr = a;
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      answers_due.delete();
      low_sel   = crbm_pkg::RAM_BANK0;
      high_sel  = crbm_pkg::ROM_SELECT;
      wr_en     = 1'b0;
      pending   = '0;
      count     = '0;
      last_addr = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result transaction with no access waiting for it");
        end else begin
          want = answers_due.pop_front();
          compare_field("read_data", out_mon.read_data, want.read_data);
          compare_field("drive_bus", 8'(out_mon.drive_bus), 8'(want.drive_bus));
          compare_field("load_request", 8'(out_mon.load_request),
                        8'(want.load_request));
          compare_field("load_id", out_mon.load_id, want.load_id);
        end
      end
      if (in_mon.valid && in_mon.ready)
        answers_due.push_back(mapper_answer(in_mon.mode, in_mon.address, in_mon.data));
    end
    outstanding = answers_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the bank mapper testbench: clock, reset, access stimulus with
// random stalls on both channels, watchdog and verdict.
// Depends on crbm_pkg, crbm_if, cartridge_ram_bank_mapper and bank_map_checker.
module tb_top;

  localparam int SEQUENCES   = 90;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_idle;
  bit   hold_request;
  int   fails;
  int   pending_results;
  bit   offset_filled [crbm_pkg::BANK_BYTES_DEF];

  crbm_in_if  in_if ();
  crbm_out_if out_if ();

  cartridge_ram_bank_mapper u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if)
  );

  bank_map_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fails),
    .outstanding (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input logic m, input logic [crbm_pkg::ADDR_W-1:0] a,
                           input logic [crbm_pkg::DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= m;
    in_if.address <= a;
    in_if.data    <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // every bank gets a byte at an offset before the console first reads it
  task automatic bus_access(input logic [crbm_pkg::ADDR_W-1:0] a,
                            input logic [crbm_pkg::DATA_W-1:0] d);
    if (a[12] && !offset_filled[a[10:0]]) begin
      for (int b = 0; b < crbm_pkg::STORE_BANKS; b++)
        send_item(1'b1, {b[1:0], a[10:0]}, 8'($urandom));
      offset_filled[a[10:0]] = 1'b1;
    end
    send_item(1'b0, a, d);
  endtask

  function automatic logic [crbm_pkg::DATA_W-1:0] latch_value();
    if ($urandom_range(9) < 6)
      return {3'b000, 3'($urandom), 1'($urandom_range(3) != 0), 1'($urandom)};
    return 8'($urandom);
  endfunction

  function automatic logic [crbm_pkg::ADDR_W-1:0] cart_address();
    if ($urandom_range(1) == 1)
      return {1'b1, 1'($urandom), {6{1'($urandom)}}, 5'($urandom)};
    return {1'b1, 12'($urandom)};
  endfunction

  function automatic logic [crbm_pkg::ADDR_W-1:0] filler_address();
    if ($urandom_range(4) != 0) return {1'b0, 12'($urandom)};
    return cart_address();
  endfunction

  initial begin
    int hold_left;
    bit hold_done;
    out_if.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("cartridge_ram_bank_mapper test failed");
    $finish;
  end

  initial begin
    int pick;
    in_if.valid   = 1'b0;
    in_if.mode    = 1'b0;
    in_if.address = '0;
    in_if.data    = '0;
    rst_n         = 1'b0;
    send_idle     = 25;
    recv_idle     = 54;
    hold_request  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // address extremes, outside and inside cartridge space
    bus_access(13'h0000, 8'h00);
    bus_access(13'h0FFF, 8'hFF);
    send_item(1'b1, 13'h1FFF, 8'hFF);
    bus_access(13'h1FFF, 8'h00);
    bus_access(13'h1800, 8'h81);
    bus_access(13'h17FF, 8'h7E);
    // multiload request, then the same address without a low-page access before it
    bus_access(13'h00FF, 8'h11);
    bus_access(crbm_pkg::LOAD_ADDR, 8'hFF);
    bus_access(crbm_pkg::LOAD_ADDR, 8'h5A);
    // pair 7 with writes enabled: high half shows RAM bank 2
    bus_access(13'h101E, 8'h22);
    bus_access(crbm_pkg::SWITCH_ADDR, 8'hAA);
    bus_access(13'h10A5, 8'h33);
    bus_access(13'h0123, 8'h44);
    bus_access(13'h1234, 8'h55);
    bus_access(13'h0ABC, 8'h66);
    bus_access(13'h0FFF, 8'h77);
    bus_access(13'h1FFF, 8'h88);
    bus_access(13'h1FFF, 8'h99);
    // pair 0 with writes enabled: timed write aimed at the ROM is dropped
    bus_access(13'h1002, 8'h01);
    bus_access(crbm_pkg::SWITCH_ADDR, 8'h02);
    bus_access(13'h1077, 8'h03);
    repeat (4) bus_access(filler_address(), 8'($urandom));
    bus_access(13'h1ABC, 8'h04);
    // writes disabled again
    bus_access(13'h1000, 8'h05);
    bus_access(crbm_pkg::SWITCH_ADDR, 8'h06);

    for (int n = 0; n < SEQUENCES; n++) begin
      if (n == SEQUENCES / 3) begin
        send_idle = 54;
        recv_idle = 25;
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
      end
      if (n == 2 * SEQUENCES / 3) begin
        send_idle    = 0;
        recv_idle    = 0;
        hold_request = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        bus_access({5'b10000, latch_value()}, 8'($urandom));
        repeat (4) bus_access(filler_address(), 8'($urandom));
        bus_access(cart_address(), 8'($urandom));
      end else if (pick < 55) begin
        bus_access({5'b10000, latch_value()}, 8'($urandom));
        bus_access(crbm_pkg::SWITCH_ADDR, 8'($urandom));
      end else if (pick < 65) begin
        bus_access({5'b00000, 8'($urandom)}, 8'($urandom));
        bus_access(crbm_pkg::LOAD_ADDR, 8'($urandom));
      end else if (pick < 72) begin
        send_item(1'b1, 13'($urandom), 8'($urandom));
      end else begin
        bus_access(13'($urandom), 8'($urandom));
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0 && pending_results == 0) begin
      $display("cartridge_ram_bank_mapper test passed");
    end else begin
      $display("cartridge_ram_bank_mapper test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/crbm_pkg.sv
rtl/core/crbm_if.sv
rtl/core/crbm_ram.sv
rtl/core/crbm_ctrl.sv
rtl/core/cartridge_ram_bank_mapper.sv
tb/bank_map_checker.sv
tb/tb_top.sv
